// File: rtl/udiv_pkg.sv
// ----------------------------------------------------------------------------
// udiv_pkg
// Shared types and the word-width constant for the pipelined unsigned divider.
// ----------------------------------------------------------------------------
package udiv_pkg;

    // Width of every operand field and of the quotient and remainder on the block's ports.
    localparam int WORD_WIDTH = 64;

    // One division request: both operands.
    typedef struct packed {
        logic [WORD_WIDTH-1:0] dividend;
        logic [WORD_WIDTH-1:0] divisor;
    } udiv_req_t;

    // One division result.
    typedef struct packed {
        logic [WORD_WIDTH-1:0] quotient;
        logic [WORD_WIDTH-1:0] remainder;
        logic                  divide_by_zero;
    } udiv_rsp_t;

    // Control bits that travel down the pipeline beside each request.
    typedef struct packed {
        logic valid;
        logic zero_div;
    } udiv_ctl_t;

endpackage

// File: rtl/udiv_stage.sv
// ----------------------------------------------------------------------------
// udiv_stage
// One registered step of restoring division: shifts the next dividend bit
// into the partial remainder and subtracts the divisor when it fits.
// ----------------------------------------------------------------------------
module udiv_stage
    import udiv_pkg::*;
#(
    parameter int W = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  udiv_ctl_t    ctl_in,
    input  logic [W-1:0] part_in,
    input  logic [W-1:0] quo_in,
    input  logic [W-1:0] den_in,
    output udiv_ctl_t    ctl_out,
    output logic [W-1:0] part_out,
    output logic [W-1:0] quo_out,
    output logic [W-1:0] den_out
);

    udiv_ctl_t    ctl_reg;
    udiv_ctl_t    ctl_next;
    logic [W-1:0] part_reg;
    logic [W-1:0] part_next;
    logic [W-1:0] quo_reg;
    logic [W-1:0] quo_next;
    logic [W-1:0] den_reg;
    logic [W-1:0] den_next;
    logic [W:0]   trial;
    logic [W:0]   diff;

    // Trial subtraction of the divisor from the shifted partial remainder.
    // The quotient register doubles as the shift register of dividend bits.
    always_comb
    begin
        trial    = {part_in, quo_in[W-1]};
        diff     = trial - {1'b0, den_in};
        ctl_next = ctl_in;
        den_next = den_in;
        if (!diff[W])
        begin
            part_next = diff[W-1:0];
            quo_next  = {quo_in[W-2:0], 1'b1};
        end
        else
        begin
            part_next = trial[W-1:0];
            quo_next  = {quo_in[W-2:0], 1'b0};
        end
    end

    // Control bits are reset; the data registers need no reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        part_reg <= part_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
    end

    assign ctl_out  = ctl_reg;
    assign part_out = part_reg;
    assign quo_out  = quo_reg;
    assign den_out  = den_reg;

endmodule

// File: rtl/unsigned_divider_64.sv
// ----------------------------------------------------------------------------
// unsigned_divider_64
// Pipelined restoring divider for unsigned operands, one quotient bit a stage.
// Structure: DATA_WIDTH subtract stages and one output register lie between an
// accepted request and its done strobe.
// Throughput: one request every cycle; busy stays low, the results cannot be
// held off, so the pipeline never stalls.
// Reset: rst_n clears the valid bits of all stages and the done strobe.
// ----------------------------------------------------------------------------
module unsigned_divider_64
    import udiv_pkg::*;
#(
    parameter int DATA_WIDTH = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  udiv_req_t req,
    output logic      busy,
    output logic      done,
    output udiv_rsp_t rsp
);

    localparam int W = DATA_WIDTH;

    udiv_ctl_t    ctl_w  [0:W];
    logic [W-1:0] part_w [0:W];
    logic [W-1:0] quo_w  [0:W];
    logic [W-1:0] den_w  [0:W];

    logic      done_reg;
    logic      done_next;
    udiv_rsp_t rsp_reg;
    udiv_rsp_t rsp_next;

    // The pipeline always advances, so a request is never refused.
    assign busy = 1'b0;

    // Pipeline entry: only the low W bits of each operand take part.
    assign ctl_w[0].valid    = start && !busy;
    assign ctl_w[0].zero_div = (req.divisor[W-1:0] == '0);
    assign part_w[0]         = '0;
    assign quo_w[0]          = req.dividend[W-1:0];
    assign den_w[0]          = req.divisor[W-1:0];

    // One stage per quotient bit, most significant bit first.
    for (genvar i = 0; i < W; i++)
    begin : g_stage
        udiv_stage #(
            .W (W)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl_in   (ctl_w[i]),
            .part_in  (part_w[i]),
            .quo_in   (quo_w[i]),
            .den_in   (den_w[i]),
            .ctl_out  (ctl_w[i+1]),
            .part_out (part_w[i+1]),
            .quo_out  (quo_w[i+1]),
            .den_out  (den_w[i+1])
        );
    end

    // Output register; a zero divisor forces ones in the low W quotient bits and a zero remainder.
    always_comb
    begin
        done_next = ctl_w[W].valid;
        if (ctl_w[W].zero_div)
        begin
            rsp_next.quotient       = WORD_WIDTH'({W{1'b1}});
            rsp_next.remainder      = '0;
            rsp_next.divide_by_zero = 1'b1;
        end
        else
        begin
            rsp_next.quotient       = WORD_WIDTH'(quo_w[W]);
            rsp_next.remainder      = WORD_WIDTH'(part_w[W]);
            rsp_next.divide_by_zero = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // Every accepted request comes out after the fixed latency.
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(W + 1) done)
        else $error("request did not complete after the pipeline latency");

    // A divide-by-zero result carries the fixed quotient and remainder.
    a_div_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.divide_by_zero) |->
            (rsp.remainder == '0) && (rsp.quotient == WORD_WIDTH'({W{1'b1}})))
        else $error("divide-by-zero result has wrong quotient or remainder");

    // For a nonzero divisor, the final partial remainder is always below the divisor.
    a_rem_range : assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_w[W].valid && !ctl_w[W].zero_div) |-> (part_w[W] < den_w[W]))
        else $error("final remainder is not below the divisor");

    // Bits above the operand width stay clear in every result.
    a_upper_clear : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((rsp.quotient >> W) == '0) && ((rsp.remainder >> W) == '0))
        else $error("result has bits set above the operand width");

endmodule
